@@ hdl/s3m_pkg.sv @@
`default_nettype none

package s3m_pkg;

  localparam int MAX_WIDTH   = 1024;
  localparam int MAX_HEIGHT  = 1024;
  localparam int SAMPLE_BITS = 16;
  localparam int CFG_W       = 11;
  localparam int CFG_IDX_W   = 2;
  localparam int COL_W       = $clog2(MAX_WIDTH);
  localparam int ROW_W       = CFG_W;
  localparam int CSUM_W      = SAMPLE_BITS + 2;
  localparam int SUM_W       = SAMPLE_BITS + 4;
  localparam int RECIP_W     = 13;
  localparam int FRAC_BITS   = 16;
  localparam int PROD_W      = SUM_W + RECIP_W + 1;

  localparam logic [RECIP_W-1:0]     RECIP_NINE = RECIP_W'(7282);
  localparam logic [FRAC_BITS-1:0]   ROUND_HALF = FRAC_BITS'(32768);
  localparam logic [SAMPLE_BITS-1:0] SAMPLE_MAX = {SAMPLE_BITS{1'b1}};

  localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = CFG_IDX_W'(1);

  localparam logic [CFG_W-1:0] WIDTH_MIN   = CFG_W'(4);
  localparam logic [CFG_W-1:0] WIDTH_MAX   = CFG_W'(MAX_WIDTH);
  localparam logic [CFG_W-1:0] HEIGHT_MIN  = CFG_W'(3);
  localparam logic [CFG_W-1:0] HEIGHT_MAX  = CFG_W'(MAX_HEIGHT);
  localparam logic [CFG_W-1:0] RESET_SIZE  = CFG_W'(512);

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] top;
    logic [SAMPLE_BITS-1:0] mid;
    logic [SAMPLE_BITS-1:0] bot;
  } col_t;

  typedef struct packed {
    logic has_result;
    logic border;
    logic last;
  } flags_t;

  function automatic logic [CFG_W-1:0] clamp_size(input logic [CFG_W-1:0] v,
                                                   input logic [CFG_W-1:0] lo,
                                                   input logic [CFG_W-1:0] hi);
    logic [CFG_W-1:0] r;
    r = v;
    if (v < lo) begin
      r = lo;
    end else if (v > hi) begin
      r = hi;
    end
    return r;
  endfunction

  function automatic logic [SAMPLE_BITS-1:0] mean_of_sum(input logic [SUM_W-1:0] s);
    logic [PROD_W-1:0] p;
    logic [PROD_W-FRAC_BITS-1:0] q;
    logic [SAMPLE_BITS-1:0] r;
    p = PROD_W'(s) * PROD_W'(RECIP_NINE) + PROD_W'(ROUND_HALF);
    q = p[PROD_W-1:FRAC_BITS];
    if (q > (PROD_W-FRAC_BITS)'(SAMPLE_MAX)) begin
      r = SAMPLE_MAX;
    end else begin
      r = q[SAMPLE_BITS-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

@@ hdl/stencil_3x3_mean_stream_core.sv @@
`default_nettype none

// Channel   Handshake             Payload
// src       src_valid/src_stall   sample, pad
// res       res_valid/res_stall   value, last
// cfg       cfg_write             cfg_index, cfg_data
//
// One item per clock unless res stalls; path: stage 1, cells, sum, output reg.
// The line stores are read at the accept edge and written when it leaves stage 1.
// Reset is synchronous, clears the position and the stage valid bits, and sets
// the size registers to 512; the line stores and the window need no clearing.
// A stall on res holds the output register; bubbles in the pipeline still fill.

module stencil_3x3_mean_stream_core (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              src_valid,
  output logic                                   src_stall,
  input  wire logic [s3m_pkg::SAMPLE_BITS-1:0]   sample,
  input  wire logic                              pad,
  output logic                                   res_valid,
  input  wire logic                              res_stall,
  output logic [s3m_pkg::SAMPLE_BITS-1:0]        value,
  output logic                                   last,
  input  wire logic                              cfg_write,
  input  wire logic [s3m_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [s3m_pkg::CFG_W-1:0]         cfg_data
);

  import s3m_pkg::*;

  logic [CFG_W-1:0] wid;
  logic [CFG_W-1:0] hgt;
  logic [COL_W-1:0] col;
  logic [ROW_W-1:0] row;

  logic rdy1, rdy2, rdy3, rdy4;
  logic acc, mv1, mv2, mv3;

  logic                   v1;
  logic [SAMPLE_BITS-1:0] x1;
  logic [COL_W-1:0]       col1;
  flags_t                 f1;

  logic                   v2;
  flags_t                 f2;

  logic                   v3;
  logic [SUM_W-1:0]       sum3;
  logic [SAMPLE_BITS-1:0] centre3;
  flags_t                 f3;

  flags_t                 f_new;
  logic [CFG_W-1:0]       col_inc;
  logic [SAMPLE_BITS-1:0] top_rd;
  logic [SAMPLE_BITS-1:0] mid_rd;

  col_t                   cin;
  col_t                   c0, c1, c2;
  logic [CSUM_W-1:0]      s0, s1, s2;

  assign rdy4 = !res_valid || !res_stall;
  assign rdy3 = !v3 || rdy4;
  assign rdy2 = !v2 || rdy3;
  assign rdy1 = !v1 || rdy2;
  assign src_stall = !rdy1;
  assign acc = src_valid && rdy1;
  assign mv1 = v1 && rdy2;
  assign mv2 = v2 && rdy3;
  assign mv3 = v3 && rdy4;

  assign col_inc = CFG_W'(col) + CFG_W'(1);

  always_comb begin
    f_new.has_result = (row >= ROW_W'(2)) || ((row == ROW_W'(1)) && (col != '0));
    f_new.border     = (col == '0) || (col == COL_W'(1)) || (row == ROW_W'(1)) ||
                       (row == ROW_W'(hgt));
    f_new.last       = (row == ROW_W'(hgt) + ROW_W'(1)) && (col == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wid <= RESET_SIZE;
      hgt <= RESET_SIZE;
      col <= '0;
      row <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_GRID_WIDTH: begin
          wid <= clamp_size(cfg_data, WIDTH_MIN, WIDTH_MAX);
          col <= '0;
          row <= '0;
        end
        REG_GRID_HEIGHT: begin
          hgt <= clamp_size(cfg_data, HEIGHT_MIN, HEIGHT_MAX);
          col <= '0;
          row <= '0;
        end
        default: begin
        end
      endcase
    end else if (acc) begin
      if (f_new.last) begin
        col <= '0;
        row <= '0;
      end else if (col_inc >= wid) begin
        col <= '0;
        row <= row + ROW_W'(1);
      end else begin
        col <= col_inc[COL_W-1:0];
      end
    end
  end

  s3m_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(MAX_WIDTH)) u_upper (
    .clk   (clk),
    .we    (mv1),
    .waddr (col1),
    .wdata (mid_rd),
    .re    (acc),
    .raddr (col),
    .rdata (top_rd)
  );

  s3m_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(MAX_WIDTH)) u_middle (
    .clk   (clk),
    .we    (mv1),
    .waddr (col1),
    .wdata (x1),
    .re    (acc),
    .raddr (col),
    .rdata (mid_rd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (rdy1) begin
      v1 <= src_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      x1   <= pad ? '0 : sample;
      col1 <= col;
      f1   <= f_new;
    end
  end

  always_comb begin
    cin.top = top_rd;
    cin.mid = mid_rd;
    cin.bot = x1;
  end

  s3m_cell u_cell2 (.clk(clk), .shift(mv1), .din(cin), .dout(c2), .col_sum(s2));
  s3m_cell u_cell1 (.clk(clk), .shift(mv1), .din(c2),  .dout(c1), .col_sum(s1));
  s3m_cell u_cell0 (.clk(clk), .shift(mv1), .din(c1),  .dout(c0), .col_sum(s0));

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (rdy2) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (mv1) begin
      f2 <= f1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (rdy3) begin
      v3 <= v2 && f2.has_result;
    end
  end

  always_ff @(posedge clk) begin
    if (mv2) begin
      sum3    <= SUM_W'(s0) + SUM_W'(s1) + SUM_W'(s2);
      centre3 <= c1.mid;
      f3      <= f2;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (rdy4) begin
      res_valid <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (mv3) begin
      value <= f3.border ? centre3 : mean_of_sum(sum3);
      last  <= f3.last;
    end
  end

endmodule

`default_nettype wire

@@ hdl/s3m_ram.sv @@
`default_nettype none

module s3m_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

@@ hdl/s3m_cell.sv @@
`default_nettype none

module s3m_cell (
  input  wire logic                         clk,
  input  wire logic                         shift,
  input  wire s3m_pkg::col_t                din,
  output s3m_pkg::col_t                     dout,
  output logic [s3m_pkg::CSUM_W-1:0]        col_sum
);

  import s3m_pkg::*;

  always_ff @(posedge clk) begin
    if (shift) begin
      dout <= din;
    end
  end

  assign col_sum = CSUM_W'(dout.top) + CSUM_W'(dout.mid) + CSUM_W'(dout.bot);

endmodule

`default_nettype wire
